@@ design/radial_power_warp_address_top_macros.svh @@
// ----------------------------------------------------------------------------
// radial_power_warp_address_top_macros.svh
// Assertion macros shared by the warp address generator.
// ----------------------------------------------------------------------------
`ifndef RADIAL_POWER_WARP_ADDRESS_TOP_MACROS_SVH
`define RADIAL_POWER_WARP_ADDRESS_TOP_MACROS_SVH

// check while out of reset
`define RPWA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define RPWA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rpwa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpwa_pkg
// Shared constants and elaboration-time helpers for the warp address pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwa_pkg;

  localparam int FIELD_W          = 12;
  localparam int COORD_BITS_DEF   = 12;
  localparam int RATIO_FRAC_DEF   = 16;
  localparam int LOG_FRAC         = 20;
  localparam int MANT_W           = 31;
  localparam int RADIUS_W         = 17;
  localparam int POWER_W          = 16;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Q4 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_Q12 = 8'd3;

  localparam logic [POWER_W-1:0] POWER_RESET = 16'd4096;

  // integer square root, constant use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q1.30
  function automatic logic [63:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int j = 1; j <= LOG_FRAC; j++) begin
      if (j <= k) c = isqrt64(c << 30);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/rpwa_front.sv @@
// ----------------------------------------------------------------------------
// rpwa_front
// Offsets, squared distance and radius, leading-one search and mantissa
// normalization, over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwa_front
  import rpwa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CB  = COORD_BITS,
  localparam int CW  = 4*CB + 3,
  localparam int DW  = 2*CB + 9,
  localparam int VW  = (DW > 2*RADIUS_W) ? DW : 2*RADIUS_W,
  localparam int EBW = $clog2(VW)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FIELD_W-1:0]   pixel_x,
  input  wire logic [FIELD_W-1:0]   pixel_y,
  input  wire logic [FIELD_W-1:0]   center_x,
  input  wire logic [FIELD_W-1:0]   center_y,
  input  wire logic [RADIUS_W-1:0]  radius_q4,
  input  wire logic [POWER_W-1:0]   power_q12,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [MANT_W-1:0]         mant_r,
  output logic [MANT_W-1:0]         mant_d,
  output logic [EBW-1:0]            exp_r,
  output logic [EBW-1:0]            exp_d,
  output logic [CW-1:0]             carry
);

  localparam int EW = (CB > FIELD_W) ? CB : FIELD_W;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  // stage 1: coordinates and signed offsets
  logic [EW-1:0] pxe, pye, cxe, cye;
  logic [CB-1:0] px_c, py_c, cx_c, cy_c;
  logic [CB-1:0] px1, py1;
  logic signed [CB:0] dx1, dy1;

  assign pxe  = EW'(pixel_x);
  assign pye  = EW'(pixel_y);
  assign cxe  = EW'(center_x);
  assign cye  = EW'(center_y);
  assign px_c = pxe[CB-1:0];
  assign py_c = pye[CB-1:0];
  assign cx_c = cxe[CB-1:0];
  assign cy_c = cye[CB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      px1 <= px_c;
      py1 <= py_c;
      dx1 <= $signed({1'b0, px_c}) - $signed({1'b0, cx_c});
      dy1 <= $signed({1'b0, py_c}) - $signed({1'b0, cy_c});
    end
  end

  // stage 2: magnitudes, squared distance and squared radius
  logic [CB-1:0] mx_c, my_c;
  logic [2*CB-1:0] sqx, sqy;
  logic [CB-1:0] px2, py2, mx2, my2;
  logic sx2, sy2;
  logic [DW-1:0] dsq2;
  logic [2*RADIUS_W-1:0] rsq2;

  assign mx_c = dx1[CB] ? CB'(-dx1) : dx1[CB-1:0];
  assign my_c = dy1[CB] ? CB'(-dy1) : dy1[CB-1:0];
  assign sqx  = mx_c * mx_c;
  assign sqy  = my_c * my_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      px2  <= px1;
      py2  <= py1;
      mx2  <= mx_c;
      my2  <= my_c;
      sx2  <= dx1[CB];
      sy2  <= dy1[CB];
      dsq2 <= DW'(({1'b0, sqx} + {1'b0, sqy})) << 8;
      rsq2 <= radius_q4 * radius_q4;
    end
  end

  // stage 3: warp decision and leading-one positions
  logic [VW-1:0] vd_c, vr_c;
  logic [EBW-1:0] ed_c, er_c;
  logic warp_c;
  logic [VW-1:0] vd3, vr3;
  logic [EBW-1:0] ed3, er3;
  logic [CW-1:0] carry3;

  assign vd_c = VW'(dsq2);
  assign vr_c = VW'(rsq2);
  assign warp_c = (radius_q4 != '0) && (power_q12 != '0) && (dsq2 != '0) &&
                  (vd_c < vr_c);

  always_comb begin
    ed_c = '0;
    er_c = '0;
    for (int i = 0; i < VW; i++) begin
      if (vd_c[i]) ed_c = EBW'(i);
      if (vr_c[i]) er_c = EBW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      vd3    <= vd_c;
      vr3    <= vr_c;
      ed3    <= ed_c;
      er3    <= er_c;
      carry3 <= {warp_c, my2, mx2, sy2, sx2, py2, px2};
    end
  end

  // stage 4: normalize to Q1.30
  logic [VW-1:0] nd_c, nr_c;

  assign nd_c = vd3 << (EBW'(VW-1) - ed3);
  assign nr_c = vr3 << (EBW'(VW-1) - er3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      mant_d <= nd_c[VW-1 -: MANT_W];
      mant_r <= nr_c[VW-1 -: MANT_W];
      exp_d  <= ed3;
      exp_r  <= er3;
      carry  <= carry3;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

@@ design/rpwa_log2.sv @@
// ----------------------------------------------------------------------------
// rpwa_log2
// Fraction bits of log2 for radius and distance, one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwa_log2
  import rpwa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CB  = COORD_BITS,
  localparam int CW  = 4*CB + 3,
  localparam int DW  = 2*CB + 9,
  localparam int VW  = (DW > 2*RADIUS_W) ? DW : 2*RADIUS_W,
  localparam int EBW = $clog2(VW),
  localparam int LW  = EBW + LOG_FRAC
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MANT_W-1:0]  mant_r,
  input  wire logic [MANT_W-1:0]  mant_d,
  input  wire logic [EBW-1:0]     exp_r,
  input  wire logic [EBW-1:0]     exp_d,
  input  wire logic [CW-1:0]      carry_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [LW-1:0]           log_r,
  output logic [LW-1:0]           log_d,
  output logic [CW-1:0]           carry_out
);

  localparam int N = LOG_FRAC;

  logic                v   [0:N];
  logic                rdy [1:N+1];
  logic [MANT_W-1:0]   mr  [0:N];
  logic [MANT_W-1:0]   md  [0:N];
  logic [LOG_FRAC-1:0] fr  [0:N];
  logic [LOG_FRAC-1:0] fd  [0:N];
  logic [EBW-1:0]      er  [0:N];
  logic [EBW-1:0]      ed  [0:N];
  logic [CW-1:0]       cy  [0:N];

  assign v[0]     = in_valid;
  assign mr[0]    = mant_r;
  assign md[0]    = mant_d;
  assign fr[0]    = '0;
  assign fd[0]    = '0;
  assign er[0]    = exp_r;
  assign ed[0]    = exp_d;
  assign cy[0]    = carry_in;
  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[1];

  for (genvar i = 1; i <= N; i++) begin : g_stage
    logic [2*MANT_W-1:0] sq_r, sq_d;
    logic [MANT_W:0]     q_r, q_d;

    // square and renormalize; an overflow sets this fraction bit
    assign sq_r = mr[i-1] * mr[i-1];
    assign sq_d = md[i-1] * md[i-1];
    assign q_r  = sq_r[2*MANT_W-1:MANT_W-1];
    assign q_d  = sq_d[2*MANT_W-1:MANT_W-1];
    assign rdy[i] = !v[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        mr[i] <= q_r[MANT_W] ? q_r[MANT_W:1] : q_r[MANT_W-1:0];
        md[i] <= q_d[MANT_W] ? q_d[MANT_W:1] : q_d[MANT_W-1:0];
        fr[i] <= fr[i-1] | (q_r[MANT_W] ? (LOG_FRAC'(1) << (LOG_FRAC - i)) : '0);
        fd[i] <= fd[i-1] | (q_d[MANT_W] ? (LOG_FRAC'(1) << (LOG_FRAC - i)) : '0);
        er[i] <= er[i-1];
        ed[i] <= ed[i-1];
        cy[i] <= cy[i-1];
      end
    end
  end

  assign out_valid = v[N];
  assign log_r     = {er[N], fr[N]};
  assign log_d     = {ed[N], fd[N]};
  assign carry_out = cy[N];

endmodule

`default_nettype wire

@@ design/rpwa_exp.sv @@
// ----------------------------------------------------------------------------
// rpwa_exp
// Scaled log difference, then 2^-t by one constant multiply per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwa_exp
  import rpwa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CB  = COORD_BITS,
  localparam int CW  = 4*CB + 3,
  localparam int DW  = 2*CB + 9,
  localparam int VW  = (DW > 2*RADIUS_W) ? DW : 2*RADIUS_W,
  localparam int EBW = $clog2(VW),
  localparam int LW  = EBW + LOG_FRAC,
  localparam int TW  = LW + POWER_W - 13,
  localparam int NW  = TW - LOG_FRAC
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [LW-1:0]      log_r,
  input  wire logic [LW-1:0]      log_d,
  input  wire logic [POWER_W-1:0] power_q12,
  input  wire logic [CW-1:0]      carry_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [MANT_W-1:0]       y_out,
  output logic [NW-1:0]           n_out,
  output logic [CW-1:0]           carry_out
);

  localparam int N = LOG_FRAC;

  logic              v   [0:N];
  logic              rdy [0:N+1];
  logic [MANT_W-1:0] y   [0:N];
  logic [TW-1:0]     t   [0:N];
  logic [CW-1:0]     cy  [0:N];

  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[0];

  // stage 0: t = (log r^2 - log d^2) * p >> 13
  logic [LW-1:0]         diff_c;
  logic [LW+POWER_W-1:0] prod_c;

  assign diff_c = (log_r > log_d) ? (log_r - log_d) : '0;
  assign prod_c = diff_c * power_q12;
  assign rdy[0] = !v[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t[0]  <= prod_c[LW+POWER_W-1:13];
      y[0]  <= MANT_W'(1) << 30;
      cy[0] <= carry_in;
    end
  end

  // fraction bits, most significant first
  for (genvar k = 1; k <= N; k++) begin : g_stage
    localparam logic [MANT_W-1:0] COEF = MANT_W'(exp_coef(k));
    logic [2*MANT_W-1:0] p;

    assign p      = y[k-1] * COEF;
    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        y[k]  <= t[k-1][LOG_FRAC-k] ? p[MANT_W+29:30] : y[k-1];
        t[k]  <= t[k-1];
        cy[k] <= cy[k-1];
      end
    end
  end

  assign out_valid = v[N];
  assign y_out     = y[N];
  assign n_out     = t[N][TW-1:LOG_FRAC];
  assign carry_out = cy[N];

endmodule

`default_nettype wire

@@ design/rpwa_back.sv @@
// ----------------------------------------------------------------------------
// rpwa_back
// Ratio rounding, offset multiply and final address, output register last.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwa_back
  import rpwa_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_DEF,
  localparam int CB  = COORD_BITS,
  localparam int RFB = RATIO_FRAC_BITS,
  localparam int CW  = 4*CB + 3,
  localparam int DW  = 2*CB + 9,
  localparam int VW  = (DW > 2*RADIUS_W) ? DW : 2*RADIUS_W,
  localparam int EBW = $clog2(VW),
  localparam int LW  = EBW + LOG_FRAC,
  localparam int TW  = LW + POWER_W - 13,
  localparam int NW  = TW - LOG_FRAC
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MANT_W-1:0]  y_in,
  input  wire logic [NW-1:0]      n_in,
  input  wire logic [CW-1:0]      carry_in,
  input  wire logic [FIELD_W-1:0] center_x,
  input  wire logic [FIELD_W-1:0] center_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [FIELD_W-1:0]      read_x,
  output logic [FIELD_W-1:0]      read_y,
  output logic                    moved
);

  localparam int EW    = (CB > FIELD_W) ? CB : FIELD_W;
  localparam int RW    = RFB + 1;
  localparam int PW    = CB + RW;
  localparam int SBASE = 30 - RFB;

  logic v1, v2, v3;
  logic r1, r2, r3;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  // stage 1: ratio = y >> (SBASE + n), rounded half up
  logic [6:0]    sh_c;
  logic [63:0]   sum_c;
  logic [RW-1:0] ratio_c;
  logic [RW-1:0] ratio1;
  logic [CW-1:0] carry1;

  assign sh_c  = 7'(SBASE) + n_in[6:0];
  assign sum_c = 64'(y_in) + (64'd1 << (sh_c - 7'd1));

  always_comb begin
    if ({1'b0, n_in} > (NW+1)'(62 - SBASE)) begin
      ratio_c = '0;
    end else begin
      ratio_c = RW'(sum_c >> sh_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      ratio1 <= ratio_c;
      carry1 <= carry_in;
    end
  end

  // stage 2: offset magnitudes times ratio
  logic [CB-1:0] mx1, my1;
  logic [PW-1:0] prx2, pry2;
  logic [CW-1:0] carry2;

  assign mx1 = carry1[2*CB+2 +: CB];
  assign my1 = carry1[3*CB+2 +: CB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      prx2   <= mx1 * ratio1;
      pry2   <= my1 * ratio1;
      carry2 <= carry1;
    end
  end

  // stage 3: round half away from zero, add to center, output register
  logic [CB-1:0] px2, py2, offx, offy, cx, cy, rx, ry;
  logic          sx2, sy2, warp2;
  logic [PW-1:0] rndx, rndy;
  logic [EW-1:0] cxe, cye, rxe, rye;

  assign px2   = carry2[0 +: CB];
  assign py2   = carry2[CB +: CB];
  assign sx2   = carry2[2*CB];
  assign sy2   = carry2[2*CB+1];
  assign warp2 = carry2[4*CB+2];
  assign rndx  = prx2 + (PW'(1) << (RFB - 1));
  assign rndy  = pry2 + (PW'(1) << (RFB - 1));
  assign offx  = rndx[RFB +: CB];
  assign offy  = rndy[RFB +: CB];
  assign cxe   = EW'(center_x);
  assign cye   = EW'(center_y);
  assign cx    = cxe[CB-1:0];
  assign cy    = cye[CB-1:0];
  assign rx    = !warp2 ? px2 : (sx2 ? cx - offx : cx + offx);
  assign ry    = !warp2 ? py2 : (sy2 ? cy - offy : cy + offy);
  assign rxe   = EW'(rx);
  assign rye   = EW'(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      read_x <= rxe[FIELD_W-1:0];
      read_y <= rye[FIELD_W-1:0];
      moved  <= (rx != px2) || (ry != py2);
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

@@ design/radial_power_warp_address_top.sv @@
// ----------------------------------------------------------------------------
// radial_power_warp_address_top
// Power-law bulge remap: source address for each output pixel coordinate.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    pixel_x, pixel_y
//  m_*       out        m_tvalid / m_tready    read_x, read_y, moved
//  cfg_*     in         cfg_valid / cfg_ready  register index, data
//
//  One word per clock sustained while m_tready stays high; 48 register
//  stages: 4 front stages, 20 log2 squaring stages, 21 exp2 stages (scale
//  plus one constant multiply per fraction bit) and 3 back stages. The first
//  stage loads at the input accept edge.
//  rst (synchronous) clears all stage valid bits and config registers.
//  Every stage holds under stall; an empty stage still takes a word, so
//  input keeps flowing while a result waits at the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_power_warp_address_top
  import rpwa_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [2*FIELD_W-1:0]   s_tdata,   // pixel_x, pixel_y
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [2*FIELD_W-1:0]        m_tdata,   // read_x, read_y
  output logic [0:0]                  m_tuser,   // moved
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int CW  = 4*CB + 3;
  localparam int DW  = 2*CB + 9;
  localparam int VW  = (DW > 2*RADIUS_W) ? DW : 2*RADIUS_W;
  localparam int EBW = $clog2(VW);
  localparam int LW  = EBW + LOG_FRAC;
  localparam int TW  = LW + POWER_W - 13;
  localparam int NW  = TW - LOG_FRAC;

  // configuration registers
  logic [FIELD_W-1:0]  center_x, center_y;
  logic [RADIUS_W-1:0] radius_q4;
  logic [POWER_W-1:0]  power_q12;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      radius_q4 <= '0;
      power_q12 <= POWER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:  center_x  <= cfg_data[FIELD_W-1:0];
        REG_CENTER_Y:  center_y  <= cfg_data[FIELD_W-1:0];
        REG_RADIUS_Q4: radius_q4 <= cfg_data[RADIUS_W-1:0];
        REG_POWER_Q12: power_q12 <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // front
  logic              f_valid, f_ready;
  logic [MANT_W-1:0] f_mr, f_md;
  logic [EBW-1:0]    f_er, f_ed;
  logic [CW-1:0]     f_carry;

  rpwa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pixel_x   (s_tdata[FIELD_W-1:0]),
    .pixel_y   (s_tdata[2*FIELD_W-1:FIELD_W]),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_q4 (radius_q4),
    .power_q12 (power_q12),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .mant_r    (f_mr),
    .mant_d    (f_md),
    .exp_r     (f_er),
    .exp_d     (f_ed),
    .carry     (f_carry)
  );

  // log2
  logic          l_valid, l_ready;
  logic [LW-1:0] l_r, l_d;
  logic [CW-1:0] l_carry;

  rpwa_log2 #(.COORD_BITS(COORD_BITS)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .mant_r    (f_mr),
    .mant_d    (f_md),
    .exp_r     (f_er),
    .exp_d     (f_ed),
    .carry_in  (f_carry),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .log_r     (l_r),
    .log_d     (l_d),
    .carry_out (l_carry)
  );

  // exp2
  logic              e_valid, e_ready;
  logic [MANT_W-1:0] e_y;
  logic [NW-1:0]     e_n;
  logic [CW-1:0]     e_carry;

  rpwa_exp #(.COORD_BITS(COORD_BITS)) u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (l_valid),
    .in_ready  (l_ready),
    .log_r     (l_r),
    .log_d     (l_d),
    .power_q12 (power_q12),
    .carry_in  (l_carry),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .y_out     (e_y),
    .n_out     (e_n),
    .carry_out (e_carry)
  );

  // back end and output register
  logic [FIELD_W-1:0] read_x, read_y;
  logic               moved;

  rpwa_back #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .y_in      (e_y),
    .n_in      (e_n),
    .carry_in  (e_carry),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .read_x    (read_x),
    .read_y    (read_y),
    .moved     (moved)
  );

  assign m_tdata = {read_y, read_x};
  assign m_tuser = moved;

  // checks
`include "radial_power_warp_address_top_macros.svh"

  `RPWA_ASSERT(a_ready_when_drained, (!m_tvalid || m_tready) |-> s_tready, "input stalled with output free")
  `RPWA_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

@@ sim/radial_power_warp_address_checker.sv @@
// ----------------------------------------------------------------------------
// radial_power_warp_address_checker
// Watches the pixel, result and register channels of the warp address block,
// predicts the source coordinate of every accepted pixel word and compares
// each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_power_warp_address_checker
  import rpwa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [2*FIELD_W-1:0]  s_tdata,   // pixel_x, pixel_y
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [2*FIELD_W-1:0]  m_tdata,   // read_x, read_y
  input  logic [0:0]            m_tuser,   // moved
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [11:0] read_x;
    logic [11:0] read_y;
    logic        moved;
  } src_addr_t;

  localparam longint unsigned Q30 = 64'd1 << 30;

  src_addr_t       src_q[$];
  logic [11:0]     cen_x, cen_y;
  logic [16:0]     rad_q4;
  logic [15:0]     pow_q12;
  longint unsigned root_coef [1:20];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // log2 in Q.20 by repeated squaring of the Q1.30 mantissa
  function automatic longint unsigned log2_q20(input longint unsigned v);
    int unsigned     e;
    longint unsigned m, acc;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
    acc = longint'(e) << 20;
    for (int i = 1; i <= 20; i++) begin
      m = (m * m) >> 30;
      if (m >= 2 * Q30) begin
        m >>= 1;
        acc |= 64'd1 << (20 - i);
      end
    end
    return acc;
  endfunction

  // 2^-t, t in Q.20, returned as a Q.16 ratio
  function automatic longint unsigned ratio_q16(input longint unsigned t);
    longint unsigned n, f, y, s;
    n = t >> 20;
    f = t & 64'hFFFFF;
    y = Q30;
    for (int k = 1; k <= 20; k++)
      if ((f >> (20 - k)) & 1) y = (y * root_coef[k]) >> 30;
    s = 14 + n;
    if (s > 62) return 0;
    return (y + (64'd1 << (s - 1))) >> s;
  endfunction

  // center plus offset scaled by the ratio, rounded half away from zero
  function automatic logic [11:0] pull_axis(input logic [11:0] c, input longint d,
                                            input longint unsigned ratio);
    longint unsigned mag, off;
    mag = (d < 0) ? -d : d;
    off = (mag * ratio + (64'd1 << 15)) >> 16;
    return (d < 0) ? 12'(c - off) : 12'(c + off);
  endfunction

  function automatic src_addr_t predict_source(input logic [11:0] px, input logic [11:0] py);
    src_addr_t       r;
    longint          dx, dy;
    longint unsigned dsq, rsq, lr, ld, diff, ratio;
    dx = longint'(px) - longint'(cen_x);
    dy = longint'(py) - longint'(cen_y);
    dsq = (dx * dx + dy * dy) << 8;
    rsq = longint'(rad_q4) * longint'(rad_q4);
    r.read_x = px;
    r.read_y = py;
    if (rad_q4 != 0 && pow_q12 != 0 && dsq != 0 && dsq < rsq) begin
      lr = log2_q20(rsq);
      ld = log2_q20(dsq);
      diff = (lr > ld) ? lr - ld : 0;
      ratio = ratio_q16((diff * pow_q12) >> 13);
      r.read_x = pull_axis(cen_x, dx, ratio);
      r.read_y = pull_axis(cen_y, dy, ratio);
    end
    r.moved = (r.read_x != px) || (r.read_y != py);
    return r;
  endfunction

  initial begin
    longint unsigned c;
    c = Q30 >> 1;
    for (int k = 1; k <= 20; k++) begin
      c = int_sqrt(c << 30);
      root_coef[k] = c;
    end
  end

  assign pending = src_q.size();

  always @(posedge clk) begin
    src_addr_t exp_w;
    if (rst) begin
      cen_x   <= '0;
      cen_y   <= '0;
      rad_q4  <= '0;
      pow_q12 <= POWER_RESET;
      errors  <= 0;
      src_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:  cen_x   <= cfg_data[11:0];
          REG_CENTER_Y:  cen_y   <= cfg_data[11:0];
          REG_RADIUS_Q4: rad_q4  <= cfg_data[16:0];
          REG_POWER_Q12: pow_q12 <= cfg_data[15:0];
          default: ;
        endcase
      end
      // pixel word in, appended at the tail
      if (s_tvalid && s_tready)
        src_q.insert(src_q.size(), predict_source(s_tdata[11:0], s_tdata[23:12]));
      // result word out
      if (m_tvalid && m_tready) begin
        if (src_q.size() == 0) begin
          if (errors < 10) $display("result word with nothing expected: %h", m_tdata);
          errors <= errors + 1;
        end else begin
          exp_w = src_q.pop_front();
          if (exp_w.read_x != m_tdata[11:0] || exp_w.read_y != m_tdata[23:12] ||
              exp_w.moved != m_tuser[0]) begin
            if (errors < 10)
              $display("mismatch: expected x=%0d y=%0d moved=%0d, got x=%0d y=%0d moved=%0d",
                       exp_w.read_x, exp_w.read_y, exp_w.moved,
                       m_tdata[11:0], m_tdata[23:12], m_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/radial_power_warp_address_top_tb.sv @@
// ----------------------------------------------------------------------------
// radial_power_warp_address_top_tb
// Drives pixel coordinates through the warp address block under a series of
// register settings and idle/stall patterns; the checker scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_power_warp_address_top_tb;
  import rpwa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [2*FIELD_W-1:0]  s_tdata = '0;   // pixel_x, pixel_y
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [2*FIELD_W-1:0]  m_tdata;        // read_x, read_y
  logic [0:0]            m_tuser;        // moved
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors, pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  logic [11:0] cx_now, cy_now;
  logic [16:0] rad_now;

  always #5 clk = ~clk;

  radial_power_warp_address_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  radial_power_warp_address_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // result side backpressure
  always @(negedge clk) begin
    m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // drain, then load a full register set
  task automatic set_warp(input logic [11:0] cx, input logic [11:0] cy,
                          input logic [16:0] rad, input logic [15:0] pw);
    end_burst();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_CENTER_X, {20'($urandom), cx});
    write_reg(REG_CENTER_Y, {20'($urandom), cy});
    write_reg(REG_RADIUS_Q4, {15'($urandom), rad});
    write_reg(REG_POWER_Q12, {16'($urandom), pw});
    cx_now = cx;
    cy_now = cy;
    rad_now = rad;
  endtask

  // mostly pixels inside the radius, some anywhere in the frame
  task automatic random_pixels(input int count);
    int span, px, py;
    for (int i = 0; i < count; i++) begin
      span = (rad_now >> 4) + 2;
      if (span > 4095) span = 4095;
      if ($urandom_range(9) < 7) begin
        px = int'(cx_now) + $urandom_range(2 * span) - span;
        py = int'(cy_now) + $urandom_range(2 * span) - span;
        px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
        py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
      end else begin
        px = $urandom_range(4095);
        py = $urandom_range(4095);
      end
      send_pixel(12'(px), 12'(py));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // warp disabled by reset radius
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);

    // mid-frame bulge: center, just off center, edge of radius, outside
    set_warp(12'd2048, 12'd2048, 17'd300 << 4, 16'd4096);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2049, 12'd2048);
    send_pixel(12'd2047, 12'd2047);
    send_pixel(12'd2348, 12'd2048);
    send_pixel(12'd2347, 12'd2048);
    send_pixel(12'd1748, 12'd2048);
    send_pixel(12'd2200, 12'd1900);
    send_pixel(12'd0, 12'd0);

    // largest radius and power from the corner
    set_warp(12'd0, 12'd0, 17'h1FFFF, 16'hFFFF);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1000, 12'd3000);
    send_pixel(12'd4095, 12'd0);

    // zero power disables warp
    set_warp(12'd4095, 12'd4095, 17'h1FFFF, 16'd0);
    send_pixel(12'd4000, 12'd4000);
    send_pixel(12'd0, 12'd0);

    // tiny power from far corner, small fractional radius
    set_warp(12'd4095, 12'd4095, 17'h1FFFF, 16'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4094, 12'd4095);
    set_warp(12'd100, 12'd100, 17'd17, 16'd8192);
    send_pixel(12'd101, 12'd100);
    send_pixel(12'd100, 12'd99);

    // random settings across the four idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 37) : 0;
      recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 37 : 0;
      for (int s = 0; s < 5; s++) begin
        set_warp(12'($urandom), 12'($urandom),
                 ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(8000)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12000)));
        if (ph == 0 && s == 2) begin
          // long output hold-off while input keeps coming
          fork
            begin
              hold_off = 1'b1;
              for (int c = 0; c < 400; c++) @(posedge clk);
              hold_off = 1'b0;
            end
            random_pixels(50);
          join
        end else begin
          random_pixels(50);
        end
      end
    end

    end_burst();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d pixel words over %0d register writes, four idle/stall patterns",
             pixels_sent, cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
